[hdl/dpt_pkg.sv]
// Package for the device provisioning table: sizes, codes and the shared record types.
// Depends on nothing; every other file of the block but dpt_ram refers to it by scoped names.

package dpt_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  // Stream and configuration bus widths.
  localparam int unsigned InDataW  = 232;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 4;

  // Register index taken from paddr[3] (registers sit on 8-byte slots).
  localparam logic [0:0] RegIdxGatewayId = 1'b0;

  // The UID counter starts here after reset.
  localparam logic [15:0] UidCounterReset = 16'd2;

  typedef enum logic [1:0] {
    FUNC_HELLO   = 2'd0,
    FUNC_REQUEST = 2'd1,
    FUNC_DATA    = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_ACK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_UNKNOWN     = 2'd0,
    ST_REQUESTED   = 2'd1,
    ST_PROVISIONED = 2'd2,
    ST_REVOKED     = 2'd3
  } entry_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } ctrl_state_e;

  // One table entry as it is kept in the table memory.
  typedef struct packed {
    logic [63:0]   uid;
    entry_status_e status;
    logic [31:0]   high_seq;
    logic [15:0]   rssi;
    logic [7:0]    snr;
    logic [31:0]   seen_ms;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One incoming message.
  typedef struct packed {
    func_e       func;
    logic [63:0] device_uid;
    logic [47:0] target_gateway;
    logic [15:0] msg_seq16;
    logic [15:0] hello_nonce;
    logic [31:0] data_seq32;
    logic [15:0] rssi;
    logic [7:0]  snr;
    logic [31:0] now_ms;
  } item_t;

  // One reply.
  typedef struct packed {
    action_e     action;
    logic [63:0] reply_uid;
    logic        ack_status;
    logic [15:0] seq_echo;
    logic [15:0] nonce_echo;
    logic        accepted;
  } res_t;

  // Access request from the controller to the table memory.
  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
  } ram_req_t;

endpackage

[hdl/dpt_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; the table memory of the block is one instance of it.

module dpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dpt_cfg_regs.sv]
// APB-style register port holding the gateway identity.
// Depends on dpt_pkg for bus widths and the register index.

module dpt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpt_pkg::CfgAddrW-1:0]  paddr,
  input  logic [dpt_pkg::CfgDataW-1:0]  pwdata,
  output logic [dpt_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output logic [47:0]                   gateway_id_o
);

  logic [47:0] gateway_id_q;
  logic [47:0] gateway_id_d;
  logic        sel_gateway_id;

  // Registers lie on 8-byte slots, so bit 3 selects the register.
  assign sel_gateway_id = (paddr[3] == dpt_pkg::RegIdxGatewayId);

  // Write decode.
  always_comb begin
    gateway_id_d = gateway_id_q;
    if (psel && penable && pwrite && sel_gateway_id) begin
      gateway_id_d = pwdata[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gateway_id_q <= '0;
    end else begin
      gateway_id_q <= gateway_id_d;
    end
  end

  // Read data and ready; the port never waits.
  assign prdata       = sel_gateway_id ? {16'd0, gateway_id_q} : '0;
  assign pready       = 1'b1;
  assign gateway_id_o = gateway_id_q;

endmodule

[hdl/dpt_ctrl.sv]
// Sequencer of the provisioning table: scans the table memory, decides the reply,
// writes the entry back and holds the reply in an output register. Depends on dpt_pkg.

module dpt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  dpt_pkg::item_t               item_i,
  input  logic [47:0]                  gateway_id_i,
  output dpt_pkg::ram_req_t            ram_o,
  input  dpt_pkg::entry_t              ram_rdata_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output dpt_pkg::res_t                res_o
);

  localparam logic [dpt_pkg::IdxW:0]   DepthCnt = (dpt_pkg::IdxW + 1)'(dpt_pkg::TableDepth);
  localparam logic [dpt_pkg::IdxW-1:0] LastIdx  = dpt_pkg::IdxW'(dpt_pkg::TableDepth - 1);

  dpt_pkg::ctrl_state_e          state_q, state_d;
  dpt_pkg::item_t                item_q, item_d;
  logic [dpt_pkg::IdxW:0]        scan_q, scan_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [dpt_pkg::IdxW-1:0]      chk_idx_q, chk_idx_d;
  logic                          hit_q, hit_d;
  logic [dpt_pkg::IdxW-1:0]      hit_idx_q, hit_idx_d;
  dpt_pkg::entry_t               ent_q, ent_d;
  logic [dpt_pkg::TableDepth-1:0] valid_q, valid_d;
  logic [15:0]                   uid_counter_q, uid_counter_d;
  dpt_pkg::res_t                 res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  dpt_pkg::res_t                 out_q, out_d;

  logic                          accept;
  logic                          hit_now;
  logic                          free_found;
  logic [dpt_pkg::IdxW-1:0]      free_idx;
  dpt_pkg::entry_t               new_ent;

  assign accept = item_valid_i && item_ready_o;

  // Lowest free entry, taken from the valid flags.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = dpt_pkg::TableDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = dpt_pkg::IdxW'(i);
      end
    end
  end

  // The entry read in the previous cycle matches the message sender.
  assign hit_now = chk_vld_q && valid_q[chk_idx_q] &&
                   (ram_rdata_i.uid == item_q.device_uid);

  // Next state, table access and reply decision.
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    scan_d        = scan_q;
    chk_vld_d     = 1'b0;
    chk_idx_d     = chk_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    ent_d         = ent_q;
    valid_d       = valid_q;
    uid_counter_d = uid_counter_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    item_ready_o  = 1'b0;
    new_ent       = '0;

    ram_o         = '0;
    ram_o.raddr   = scan_q[dpt_pkg::IdxW-1:0];

    // The output register frees up when its beat is taken.
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dpt_pkg::S_IDLE: begin
        item_ready_o = 1'b1;
        if (accept) begin
          item_d    = item_i;
          scan_d    = '0;
          res_d     = '0;
          res_d.action = dpt_pkg::ACT_NONE;
          priority if (item_i.func == dpt_pkg::FUNC_HELLO && item_i.device_uid == '0) begin
            // Fresh device: offer gateway ID and counter.
            res_d.action     = dpt_pkg::ACT_OFFER;
            res_d.reply_uid  = {gateway_id_i, uid_counter_q};
            res_d.seq_echo   = item_i.msg_seq16;
            res_d.nonce_echo = item_i.hello_nonce;
            uid_counter_d    = uid_counter_q + 16'd1;
            state_d          = dpt_pkg::S_RESP;
          end else if (item_i.func == dpt_pkg::FUNC_RSVD) begin
            state_d = dpt_pkg::S_RESP;
          end else if (item_i.func == dpt_pkg::FUNC_REQUEST &&
                       item_i.target_gateway != gateway_id_i) begin
            state_d = dpt_pkg::S_RESP;
          end else begin
            state_d = dpt_pkg::S_SCAN;
          end
        end
      end

      dpt_pkg::S_SCAN: begin
        // One read per cycle; the compare comes in the cycle after the read.
        if (scan_q < DepthCnt) begin
          ram_o.re  = 1'b1;
          scan_d    = scan_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[dpt_pkg::IdxW-1:0];
        end
        priority if (hit_now) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
          ent_d     = ram_rdata_i;
          chk_vld_d = 1'b0;
          state_d   = dpt_pkg::S_UPDATE;
        end else if (chk_vld_q && chk_idx_q == LastIdx) begin
          hit_d     = 1'b0;
          chk_vld_d = 1'b0;
          state_d   = dpt_pkg::S_UPDATE;
        end else begin
          // No decision yet; keep scanning.
          state_d = dpt_pkg::S_SCAN;
        end
      end

      dpt_pkg::S_UPDATE: begin
        // Fresh entry for an allocation on a miss.
        new_ent.uid    = item_q.device_uid;
        new_ent.status = dpt_pkg::ST_PROVISIONED;
        ram_o.waddr    = hit_q ? hit_idx_q : free_idx;
        state_d        = dpt_pkg::S_RESP;

        unique case (item_q.func)
          dpt_pkg::FUNC_HELLO: begin
            res_d.action    = dpt_pkg::ACT_ACK;
            res_d.reply_uid = item_q.device_uid;
            res_d.seq_echo  = item_q.msg_seq16;
            priority if (hit_q) begin
              if (ent_q.status == dpt_pkg::ST_REVOKED) begin
                res_d.ack_status = 1'b1;
              end else begin
                ram_o.we            = 1'b1;
                ram_o.wdata         = ent_q;
                ram_o.wdata.rssi    = item_q.rssi;
                ram_o.wdata.snr     = item_q.snr;
                ram_o.wdata.seen_ms = item_q.now_ms;
              end
            end else if (free_found) begin
              ram_o.we            = 1'b1;
              ram_o.wdata         = new_ent;
              ram_o.wdata.rssi    = item_q.rssi;
              ram_o.wdata.snr     = item_q.snr;
              ram_o.wdata.seen_ms = item_q.now_ms;
              valid_d[free_idx]   = 1'b1;
            end else begin
              res_d.ack_status = 1'b1;
            end
          end

          dpt_pkg::FUNC_REQUEST: begin
            res_d.action    = dpt_pkg::ACT_ACK;
            res_d.reply_uid = item_q.device_uid;
            res_d.seq_echo  = item_q.msg_seq16;
            priority if (hit_q) begin
              // A request overrides revocation.
              ram_o.we           = 1'b1;
              ram_o.wdata        = ent_q;
              ram_o.wdata.status = dpt_pkg::ST_PROVISIONED;
            end else if (free_found) begin
              ram_o.we          = 1'b1;
              ram_o.wdata       = new_ent;
              valid_d[free_idx] = 1'b1;
            end else begin
              res_d.ack_status = 1'b1;
            end
          end

          dpt_pkg::FUNC_DATA: begin
            // Replay guard: the sequence number must move forward.
            if (hit_q && ent_q.status == dpt_pkg::ST_PROVISIONED &&
                item_q.data_seq32 > ent_q.high_seq) begin
              ram_o.we             = 1'b1;
              ram_o.wdata          = ent_q;
              ram_o.wdata.high_seq = item_q.data_seq32;
              ram_o.wdata.rssi     = item_q.rssi;
              ram_o.wdata.snr      = item_q.snr;
              ram_o.wdata.seen_ms  = item_q.now_ms;
              res_d.accepted       = 1'b1;
            end
          end

          dpt_pkg::FUNC_RSVD: begin
            res_d = res_q;
          end

          default: begin
            res_d = res_q;
          end
        endcase
      end

      dpt_pkg::S_RESP: begin
        // Hand the reply to the output register once it is free.
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = dpt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = dpt_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dpt_pkg::S_IDLE;
      chk_vld_q     <= 1'b0;
      valid_q       <= '0;
      uid_counter_q <= dpt_pkg::UidCounterReset;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      chk_vld_q     <= chk_vld_d;
      valid_q       <= valid_d;
      uid_counter_q <= uid_counter_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    ent_q     <= ent_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[hdl/device_provisioning_table_core.sv]
// Top level of the device provisioning table: stream ports, register port and table memory.
// Depends on dpt_pkg, dpt_ram, dpt_cfg_regs and dpt_ctrl.

// A hello with a zero UID, an unknown kind or a request to another gateway is answered
// without touching the table; its reply is registered and then moved into the output
// register from the S_RESP state. Every other message scans the table memory one entry
// per cycle through its single read port and stops at the first match or after the last
// entry; the entry, where the message changes it, is then written back from S_UPDATE and
// the reply goes on through S_RESP into the output register. While the output register
// still holds a beat that the downstream side has not taken, the new reply waits in
// S_RESP. One message is in work at a time; the input opens again in the same cycle as
// the reply first sits in the output register, even if the downstream side has not yet
// taken it. The user must write configuration over the APB-style port only while the
// block is idle; the block itself does not enforce this.

module device_provisioning_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Message input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: device_uid[63:0], target_gateway[111:64], msg_seq16[127:112],
  // hello_nonce[143:128], data_seq32[175:144], rssi[191:176], snr[199:192],
  // now_ms[231:200]
  input  logic [dpt_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // Reply output.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: reply_uid[63:0], ack_status[64], seq_echo[80:65], nonce_echo[96:81],
  // accepted[97], zero fill[103:98]
  output logic [dpt_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: action[1:0]
  output logic [1:0]                    m_axis_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpt_pkg::CfgAddrW-1:0]  paddr,
  input  logic [dpt_pkg::CfgDataW-1:0]  pwdata,
  output logic [dpt_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  dpt_pkg::item_t    item;
  dpt_pkg::res_t     res;
  dpt_pkg::ram_req_t ram_req;
  logic [dpt_pkg::EntryW-1:0] ram_rdata;
  logic [47:0]       gateway_id;

  // Unpack the input beat.
  assign item.func           = dpt_pkg::func_e'(s_axis_tuser);
  assign item.device_uid     = s_axis_tdata[63:0];
  assign item.target_gateway = s_axis_tdata[111:64];
  assign item.msg_seq16      = s_axis_tdata[127:112];
  assign item.hello_nonce    = s_axis_tdata[143:128];
  assign item.data_seq32     = s_axis_tdata[175:144];
  assign item.rssi           = s_axis_tdata[191:176];
  assign item.snr            = s_axis_tdata[199:192];
  assign item.now_ms         = s_axis_tdata[231:200];

  dpt_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .gateway_id_o (gateway_id)
  );

  dpt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .gateway_id_i (gateway_id),
    .ram_o        (ram_req),
    .ram_rdata_i  (dpt_pkg::entry_t'(ram_rdata)),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Table memory: one entry per device.
  dpt_ram #(
    .Width (dpt_pkg::EntryW),
    .Depth (dpt_pkg::TableDepth)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Pack the reply beat.
  assign m_axis_tdata = {6'd0, res.accepted, res.nonce_echo, res.seq_echo,
                         res.ack_status, res.reply_uid};
  assign m_axis_tuser = res.action;

endmodule

[hdl/dpt_checker.sv]
// Port-level checks of the device provisioning table, bound to the top level.
// Depends on dpt_pkg and device_provisioning_table_core.

module dpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dpt_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  // A reply never carries the unused action code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == dpt_pkg::ACT_NONE ||
                       m_axis_tuser == dpt_pkg::ACT_OFFER ||
                       m_axis_tuser == dpt_pkg::ACT_ACK))
    else $error("reply with an undefined action");

  // A deny only travels in an ack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[64]) |-> (m_axis_tuser == dpt_pkg::ACT_ACK))
    else $error("deny status outside an ack");

  // An accepted data message produces no radio reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[97]) |-> (m_axis_tuser == dpt_pkg::ACT_NONE))
    else $error("accepted flag together with a reply");

  // One message in work at a time: the input closes after each beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second input beat taken while a message is in work");

  // A stalled reply keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled reply changed");

endmodule

bind device_provisioning_table_core dpt_checker u_dpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[sim/tb.sv]
// Self-checking testbench for device_provisioning_table_core: streams radio messages in,
// predicts every reply with a small registry scoreboard and compares field by field.
// Depends on dpt_pkg and device_provisioning_table_core only.
`timescale 1ns / 1ps

module tb;

  localparam logic [dpt_pkg::CfgAddrW-1:0] GatewayIdAddr = {dpt_pkg::RegIdxGatewayId, 3'b000};
  localparam int unsigned PoolSize = 18;

  // Registry scoreboard: mirrors the device table and queues the replies it owes.
  class registry_board;
    logic [47:0]            gateway;
    logic [15:0]            counter;
    bit                     used[dpt_pkg::TableDepth];
    logic [63:0]            uid[dpt_pkg::TableDepth];
    dpt_pkg::entry_status_e status[dpt_pkg::TableDepth];
    logic [31:0]            high_seq[dpt_pkg::TableDepth];
    logic [15:0]            rssi[dpt_pkg::TableDepth];
    logic [7:0]             snr[dpt_pkg::TableDepth];
    logic [31:0]            seen_ms[dpt_pkg::TableDepth];
    dpt_pkg::res_t          owed_replies[$];
    int                     errors, checked, msgs, offers, acks_ok, denials, data_ok;

    function new();
      gateway = '0;
      counter = dpt_pkg::UidCounterReset;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%s", what);
    endfunction

    function int find(logic [63:0] u);
      for (int i = 0; i < dpt_pkg::TableDepth; i++)
        if (used[i] && uid[i] == u) return i;
      return -1;
    endfunction

    // Takes the first free entry; a fresh entry starts requested with cleared fields.
    function int claim(logic [63:0] u);
      for (int i = 0; i < dpt_pkg::TableDepth; i++)
        if (!used[i]) begin
          used[i] = 1'b1;
          uid[i] = u;
          status[i] = dpt_pkg::ST_REQUESTED;
          high_seq[i] = '0;
          rssi[i] = '0;
          snr[i] = '0;
          seen_ms[i] = '0;
          return i;
        end
      return -1;
    endfunction

    function void stamp(int i, dpt_pkg::item_t m);
      rssi[i] = m.rssi;
      snr[i] = m.snr;
      seen_ms[i] = m.now_ms;
    endfunction

    // Works out the reply to one accepted message and updates the mirrored table.
    function void take_message(dpt_pkg::item_t m);
      dpt_pkg::res_t r;
      int            i;
      r = '0;
      msgs++;
      case (m.func)
        dpt_pkg::FUNC_HELLO: begin
          if (m.device_uid == 64'd0) begin
            r.action = dpt_pkg::ACT_OFFER;
            r.reply_uid = {gateway, counter};
            r.seq_echo = m.msg_seq16;
            r.nonce_echo = m.hello_nonce;
            counter = counter + 16'd1;
          end else begin
            r.action = dpt_pkg::ACT_ACK;
            r.reply_uid = m.device_uid;
            r.seq_echo = m.msg_seq16;
            i = find(m.device_uid);
            if (i < 0) begin
              i = claim(m.device_uid);
              if (i < 0) begin
                r.ack_status = 1'b1;
              end else begin
                status[i] = dpt_pkg::ST_PROVISIONED;
                stamp(i, m);
              end
            end else if (status[i] == dpt_pkg::ST_REVOKED) begin
              r.ack_status = 1'b1;
            end else begin
              stamp(i, m);
            end
          end
        end
        dpt_pkg::FUNC_REQUEST: begin
          if (m.target_gateway == gateway) begin
            r.action = dpt_pkg::ACT_ACK;
            r.reply_uid = m.device_uid;
            r.seq_echo = m.msg_seq16;
            i = find(m.device_uid);
            if (i < 0) i = claim(m.device_uid);
            if (i >= 0) status[i] = dpt_pkg::ST_PROVISIONED;
            else r.ack_status = 1'b1;
          end
        end
        dpt_pkg::FUNC_DATA: begin
          i = find(m.device_uid);
          if (i >= 0 && status[i] == dpt_pkg::ST_PROVISIONED &&
              m.data_seq32 > high_seq[i]) begin
            high_seq[i] = m.data_seq32;
            stamp(i, m);
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      if (r.action == dpt_pkg::ACT_OFFER) offers++;
      if (r.action == dpt_pkg::ACT_ACK && !r.ack_status) acks_ok++;
      if (r.ack_status) denials++;
      if (r.accepted) data_ok++;
      owed_replies.push_back(r);
    endfunction

    // Compares one reply beat with the oldest owed reply.
    function void match_reply(dpt_pkg::res_t got, logic [5:0] fill);
      dpt_pkg::res_t want;
      if (owed_replies.size() == 0) begin
        flag($sformatf("reply with nothing owed: act=%0d uid=%h", got.action, got.reply_uid));
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      if (got.action !== want.action || got.reply_uid !== want.reply_uid ||
          got.ack_status !== want.ack_status || got.seq_echo !== want.seq_echo ||
          got.nonce_echo !== want.nonce_echo || got.accepted !== want.accepted ||
          fill !== 6'd0)
        flag({$sformatf("reply %0d mismatch: expected act=%0d uid=%h deny=%0d seq=%h ",
                        checked, want.action, want.reply_uid, want.ack_status,
                        want.seq_echo),
              $sformatf("nonce=%h acc=%0d fill=00, got act=%0d uid=%h deny=%0d seq=%h ",
                        want.nonce_echo, want.accepted, got.action, got.reply_uid,
                        got.ack_status, got.seq_echo),
              $sformatf("nonce=%h acc=%0d fill=%h", got.nonce_echo, got.accepted, fill)});
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [dpt_pkg::InDataW-1:0]  s_axis_tdata;
  logic [1:0]                   s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dpt_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0]                   m_axis_tuser;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dpt_pkg::CfgAddrW-1:0] paddr;
  logic [dpt_pkg::CfgDataW-1:0] pwdata;
  logic [dpt_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  registry_board sb;
  logic [63:0]   pool[PoolSize];
  int            burst_left = 0;
  int            rx_mode = 0;
  int            rx_mode_left = 0;
  int            settings = 0;

  device_provisioning_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: switches at random between stall styles.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(16, 200);
    end else begin
      rx_mode_left--;
    end
    if (rx_mode == 0) m_axis_tready <= 1'b1;
    else if (rx_mode == 1) m_axis_tready <= $urandom_range(0, 1);
    else if (rx_mode == 2) m_axis_tready <= ($urandom_range(0, 7) != 0);
    else m_axis_tready <= ($urandom_range(0, 4) == 0);
  end

  // Reply monitor: every accepted reply beat is checked against the scoreboard.
  always @(posedge clk_i) begin
    dpt_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.action     = dpt_pkg::action_e'(m_axis_tuser);
      got.reply_uid  = m_axis_tdata[63:0];
      got.ack_status = m_axis_tdata[64];
      got.seq_echo   = m_axis_tdata[80:65];
      got.nonce_echo = m_axis_tdata[96:81];
      got.accepted   = m_axis_tdata[97];
      sb.match_reply(got, m_axis_tdata[103:98]);
    end
  end

  function automatic dpt_pkg::item_t msg(dpt_pkg::func_e f, logic [63:0] u,
                                         logic [47:0] tgt, logic [15:0] s16,
                                         logic [15:0] nonce, logic [31:0] s32,
                                         logic [15:0] rs, logic [7:0] sn,
                                         logic [31:0] now);
    dpt_pkg::item_t m;
    m.func = f;
    m.device_uid = u;
    m.target_gateway = tgt;
    m.msg_seq16 = s16;
    m.hello_nonce = nonce;
    m.data_seq32 = s32;
    m.rssi = rs;
    m.snr = sn;
    m.now_ms = now;
    return m;
  endfunction

  // Sends one message beat; entered and left at a falling edge, valid left high.
  task automatic push_msg(dpt_pkg::item_t m);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {m.now_ms, m.snr, m.rssi, m.data_seq32, m.hello_nonce, m.msg_seq16,
                     m.target_gateway, m.device_uid};
    s_axis_tuser <= m.func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_message(m);
    @(negedge clk_i);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
  endtask

  // Holds the sender off until every owed reply has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.owed_replies.size() != 0);
  endtask

  // Writes the gateway ID over the register port and reads it back.
  task automatic write_gateway(logic [47:0] g);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= GatewayIdAddr;
    pwdata <= {16'($urandom), g};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.gateway = g;
    settings++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, g})
      sb.flag($sformatf("gateway readback: expected %h, got %h", {16'h0, g}, prdata));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly well-formed exchanges over a small UID pool, some noise.
  task automatic run_random_phase(int n);
    dpt_pkg::item_t m;
    int unsigned    pick;
    int             i;
    logic [31:0]    base;
    logic [63:0]    u;
    for (int k = 0; k < n; k++) begin
      pace();
      if ($urandom_range(0, 99) == 0) drain();
      pick = $urandom_range(0, 99);
      u = pool[$urandom_range(0, PoolSize - 1)];
      m = msg(dpt_pkg::FUNC_DATA, u, sb.gateway, 16'($urandom), 16'($urandom), $urandom,
              16'($urandom), 8'($urandom), $urandom);
      if (pick < 15) begin
        m.func = dpt_pkg::FUNC_HELLO;
        m.device_uid = 64'd0;
      end else if (pick < 35) begin
        m.func = dpt_pkg::FUNC_HELLO;
      end else if (pick < 55) begin
        m.func = dpt_pkg::FUNC_REQUEST;
        case ($urandom_range(0, 9))
          0: m.target_gateway = 48'({$urandom, $urandom});
          1: m.target_gateway = sb.gateway ^ (48'd1 << $urandom_range(0, 47));
          default: ;
        endcase
      end else if (pick < 92) begin
        // Data: mostly fresh sequence numbers, some replays and stale ones.
        i = sb.find(u);
        base = (i >= 0) ? sb.high_seq[i] : 32'($urandom_range(0, 100));
        case ($urandom_range(0, 29))
          0: m.data_seq32 = $urandom;
          1, 2, 3, 4, 5: m.data_seq32 = base;
          6, 7, 8: m.data_seq32 = base - 32'($urandom_range(1, 50));
          default: m.data_seq32 = base + 32'($urandom_range(1, 1000));
        endcase
      end else begin
        // Noise: anything but a hello, fully random fields.
        m.func = dpt_pkg::func_e'($urandom_range(1, 3));
        m.device_uid = {$urandom, $urandom};
        m.target_gateway = 48'({$urandom, $urandom});
      end
      push_msg(m);
    end
  endtask

  initial begin
    logic [47:0] g;
    logic [63:0] u1, u2;
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (pool[i]) pool[i] = {$urandom, $urandom} | 64'd1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: field extremes, every kind and each special case.
    u1 = 64'h8000_0000_0000_0001;
    u2 = 64'h0123_4567_89AB_CDEF;
    write_gateway(48'h0123_4567_89AB);
    g = sb.gateway;
    push_msg(msg(dpt_pkg::FUNC_HELLO, '0, '0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_HELLO, '0, '1, 16'h0000, 16'h0000, '1, '1, '1, '1));
    push_msg(msg(dpt_pkg::FUNC_HELLO, u1, '0, 16'h1234, 16'h5555, '0, 16'h8000, 8'h80, '0));
    push_msg(msg(dpt_pkg::FUNC_HELLO, u1, '0, 16'h4321, 16'hAAAA, '0, 16'h7FFF, 8'h7F, '1));
    push_msg(msg(dpt_pkg::FUNC_REQUEST, u2, g, 16'h0001, '0, '0, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_REQUEST, u2, g ^ 48'd1, 16'h0002, '0, '0, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_REQUEST, u1, g, 16'h0003, '0, '0, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_DATA, u1, '0, '0, '0, 32'd1, 16'hFFFF, 8'hFF, 32'd100));
    push_msg(msg(dpt_pkg::FUNC_DATA, u1, '0, '0, '0, 32'd1, '0, '0, 32'd101));
    push_msg(msg(dpt_pkg::FUNC_DATA, u1, '0, '0, '0, 32'd0, '0, '0, 32'd102));
    push_msg(msg(dpt_pkg::FUNC_DATA, u1, '0, '0, '0, '1, '0, '0, 32'd103));
    push_msg(msg(dpt_pkg::FUNC_DATA, u2 ^ 64'd1, '0, '0, '0, 32'd7, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_RSVD, '1, '1, '1, '1, '1, '1, '1, '1));
    push_msg(msg(dpt_pkg::FUNC_REQUEST, '0, g, 16'h00F0, '0, '0, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_DATA, '0, '0, '0, '0, 32'd5, '0, '0, '0));
    push_msg(msg(dpt_pkg::FUNC_HELLO, '1, '1, 16'hF00F, 16'h0FF0, '0, '0, '0, '0));
    pace();
    push_msg(msg(dpt_pkg::FUNC_DATA, '1, '0, '0, '0, 32'd9, '0, '0, '0));
    pace();
    push_msg(msg(dpt_pkg::FUNC_HELLO, u1, '0, '0, '0, '0, '0, '0, '0));
    drain();

    // Random phases over several gateway settings, the extremes first.
    for (int p = 0; p < 5; p++) begin
      if (p == 0) g = '0;
      else if (p == 1) g = '1;
      else g = 48'({$urandom, $urandom});
      write_gateway(g);
      run_random_phase(300);
      drain();
    end
    repeat (25) @(negedge clk_i);

    $display("Covered %0d messages over %0d gateway settings: %0d offers, %0d acks granted,",
             sb.msgs, settings, sb.offers, sb.acks_ok);
    $display("%0d denials, %0d data beats accepted; %0d replies checked, %0d errors.",
             sb.denials, sb.data_ok, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.owed_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hdl/dpt_pkg.sv
hdl/dpt_ram.sv
hdl/dpt_cfg_regs.sv
hdl/dpt_ctrl.sv
hdl/device_provisioning_table_core.sv
hdl/dpt_checker.sv
sim/tb.sv
